/* rtl/core/tst_pkg.sv */
`timescale 1ns / 1ps

package tst_pkg;

	// request payload
	typedef struct packed {
		logic        cmd;
		logic [15:0] topic_word;
		logic [7:0]  requester;
		logic [7:0]  handler_id;
	} tst_req_t;

	// response payload
	typedef struct packed {
		logic [2:0] status;
		logic [2:0] slot_index;
		logic [3:0] new_count;
	} tst_rsp_t;

	// one subscriber slot as held in a table row
	typedef struct packed {
		logic       used;
		logic [7:0] requester;
		logic [7:0] group;
		logic [7:0] handler;
	} tst_slot_t;

	localparam int SLOT_W = $bits(tst_slot_t);

	// controller -> datapath commands
	typedef struct packed {
		logic capture;
		logic commit;
	} tst_ctl_t;

	localparam logic CMD_SUBSCRIBE   = 1'b0;
	localparam logic CMD_UNSUBSCRIBE = 1'b1;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_ALREADY = 3'd3;
	localparam logic [2:0] ST_NOT_SUB = 3'd4;

endpackage

/* rtl/core/topic_subscription_table_top.sv */
`timescale 1ns / 1ps

// channel  | signals                      | direction | moves
// ---------+------------------------------+-----------+---------------------------
// req      | req_valid, req_ready, req    | in        | subscribe/unsubscribe request
// rsp      | rsp_valid, rsp_ready, rsp    | out       | status, slot, new count
//
// A request runs in two steps: accept (row read issued on the row RAM port),
// then evaluate and write back the row, so the next request is not taken
// until the current one is written back; the registered row read sets this,
// since the row is only on hand once the read register has loaded it.
// Reset clears the per-row valid flops at once, so no clearing pass is run.
// If a response is still waiting, the next request is taken and held in the
// evaluate step until the output register frees up.

module topic_subscription_table_top #(
	parameter int TOPIC_COUNT     = 256,
	parameter int GROUP_COUNT     = 256,
	parameter int SLOTS_PER_TOPIC = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  tst_pkg::tst_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output tst_pkg::tst_rsp_t rsp
);

	// capture / commit strobes from the sequencer
	tst_pkg::tst_ctl_t ctl;

	tst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.ctl      (ctl)
	);

	// request register, row RAM, slot compares, response register
	tst_dp #(
		.TOPIC_COUNT    (TOPIC_COUNT),
		.GROUP_COUNT    (GROUP_COUNT),
		.SLOTS_PER_TOPIC(SLOTS_PER_TOPIC)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.req   (req),
		.rsp   (rsp)
	);

endmodule

/* rtl/core/tst_ram.sv */
`timescale 1ns / 1ps

module tst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/tst_ctrl.sv */
`timescale 1ns / 1ps

module tst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output tst_pkg::tst_ctl_t ctl
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EVAL = 1'b1;

	logic state_q;
	logic state_d;
	logic rsp_valid_q;
	logic rsp_valid_d;

	assign req_ready   = (state_q == S_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign ctl.capture = req_valid && req_ready;
	// result goes out once the output register is free or being drained
	assign ctl.commit  = (state_q == S_EVAL) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (ctl.capture) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (ctl.commit) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rsp_valid_d = rsp_valid_q;
		if (ctl.commit) begin
			rsp_valid_d = 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

endmodule

/* rtl/core/tst_dp.sv */
`timescale 1ns / 1ps

module tst_dp #(
	parameter int TOPIC_COUNT     = 256,
	parameter int GROUP_COUNT     = 256,
	parameter int SLOTS_PER_TOPIC = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tst_pkg::tst_ctl_t ctl,
	input  tst_pkg::tst_req_t req,
	output tst_pkg::tst_rsp_t rsp
);

	localparam int TAW = (TOPIC_COUNT > 1) ? $clog2(TOPIC_COUNT) : 1;
	localparam int SW  = (SLOTS_PER_TOPIC > 1) ? $clog2(SLOTS_PER_TOPIC) : 1;
	localparam int CW  = $clog2(SLOTS_PER_TOPIC + 1);
	localparam int SLW = SLOTS_PER_TOPIC * tst_pkg::SLOT_W;
	localparam int RW  = SLW + CW;

	tst_pkg::tst_req_t req_q;
	tst_pkg::tst_rsp_t rsp_q;
	tst_pkg::tst_rsp_t rsp_d;
	logic [TOPIC_COUNT-1:0] row_valid_q;

	logic [RW-1:0] row_rd;
	logic [RW-1:0] row_wr;
	logic          row_we;

	tst_pkg::tst_slot_t [SLOTS_PER_TOPIC-1:0] slots_rd;
	tst_pkg::tst_slot_t [SLOTS_PER_TOPIC-1:0] slots_wr;
	logic [CW-1:0] cnt_rd;
	logic [CW-1:0] cnt_cur;
	logic [CW-1:0] cnt_new;

	logic [7:0]     topic;
	logic [7:0]     group;
	logic [TAW-1:0] taddr;
	logic           in_range;
	logic           rv;
	logic           any_dup;
	logic           any_match;
	logic           any_empty;
	logic [SW-1:0]  empty_idx;
	logic [SW-1:0]  match_idx;

	assign topic    = req_q.topic_word[7:0];
	assign group    = req_q.topic_word[15:8];
	assign taddr    = topic[TAW-1:0];
	assign in_range = ({1'b0, topic} < 9'(TOPIC_COUNT)) && ({1'b0, group} < 9'(GROUP_COUNT));
	assign rv       = in_range ? row_valid_q[taddr] : 1'b0;

	assign slots_rd = row_rd[SLW-1:0];
	assign cnt_rd   = row_rd[RW-1 -: CW];
	// a row never written reads as empty
	assign cnt_cur  = rv ? cnt_rd : '0;

	tst_ram #(
		.WIDTH(RW),
		.DEPTH(TOPIC_COUNT)
	) u_rows (
		.clk  (clk),
		.we   (row_we),
		.waddr(taddr),
		.wdata(row_wr),
		.re   (ctl.capture),
		.raddr(req.topic_word[TAW-1:0]),
		.rdata(row_rd)
	);

	// per-slot compares and first-hit encode
	always_comb begin
		logic used_i;
		any_dup   = 1'b0;
		any_match = 1'b0;
		any_empty = 1'b0;
		empty_idx = '0;
		match_idx = '0;
		for (int i = SLOTS_PER_TOPIC - 1; i >= 0; i--) begin
			used_i = rv && slots_rd[i].used;
			if (used_i && slots_rd[i].requester == req_q.requester) begin
				any_dup = 1'b1;
				if (slots_rd[i].group == group) begin
					any_match = 1'b1;
					match_idx = SW'(i);
				end
			end
			if (!used_i) begin
				any_empty = 1'b1;
				empty_idx = SW'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < SLOTS_PER_TOPIC; i++) begin
			slots_wr[i]      = slots_rd[i];
			slots_wr[i].used = rv && slots_rd[i].used;
		end
		cnt_new          = cnt_cur;
		rsp_d.status     = tst_pkg::ST_OK;
		rsp_d.slot_index = '0;
		rsp_d.new_count  = 4'(cnt_cur);
		if (!in_range) begin
			rsp_d.status    = tst_pkg::ST_INVALID;
			rsp_d.new_count = '0;
		end else if (req_q.cmd == tst_pkg::CMD_SUBSCRIBE) begin
			if (cnt_cur >= CW'(SLOTS_PER_TOPIC)) begin
				rsp_d.status = tst_pkg::ST_FULL;
			end else if (any_dup) begin
				rsp_d.status = tst_pkg::ST_ALREADY;
			end else if (any_empty) begin
				cnt_new                      = CW'(cnt_cur + 1'b1);
				slots_wr[empty_idx].used      = 1'b1;
				slots_wr[empty_idx].requester = req_q.requester;
				slots_wr[empty_idx].group     = group;
				slots_wr[empty_idx].handler   = req_q.handler_id;
				rsp_d.slot_index             = 3'(empty_idx);
				rsp_d.new_count              = 4'(cnt_new);
			end else begin
				rsp_d.status = tst_pkg::ST_FULL;
			end
		end else begin
			if (any_match) begin
				if (cnt_cur != '0) begin
					cnt_new = CW'(cnt_cur - 1'b1);
				end
				slots_wr[match_idx].used = 1'b0;
				rsp_d.slot_index        = 3'(match_idx);
				rsp_d.new_count         = 4'(cnt_new);
			end else begin
				rsp_d.status = tst_pkg::ST_NOT_SUB;
			end
		end
	end

	assign row_wr = {cnt_new, slots_wr};
	assign row_we = ctl.commit && (rsp_d.status == tst_pkg::ST_OK);
	assign rsp    = rsp_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			req_q <= req;
		end
		if (ctl.commit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (row_we) begin
			row_valid_q[taddr] <= 1'b1;
		end
	end

endmodule

/* rtl/core/tst_checker.sv */
`timescale 1ns / 1ps

module tst_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input tst_pkg::tst_req_t req,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input tst_pkg::tst_rsp_t rsp
);

	// stalled request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed while stalled");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request in flight at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == tst_pkg::ST_INVALID |->
			rsp.slot_index == 3'd0 && rsp.new_count == 4'd0)
		else $error("invalid response carries slot or count");

	a_reject_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != tst_pkg::ST_OK |-> rsp.slot_index == 3'd0)
		else $error("rejected response carries a slot");

endmodule

bind topic_subscription_table_top tst_checker u_chk (.*);
